// ----- hw/rtl/teq_pkg.sv -----
// Shared constants and codes for the timer expiry queue.
package teq_pkg;

  // Number of timer slots held in the slot memories (supported range 2 to 16, set by the 4-bit slot ports).
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // Request kinds.
  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_REMOVE  = 2'd1;
  localparam logic [1:0] KIND_PROCESS = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_ACK         = 2'd0;
  localparam logic [1:0] ST_FIRED       = 2'd1;
  localparam logic [1:0] ST_NONE        = 2'd2;
  localparam logic [1:0] ST_IDLE_REMOVE = 2'd3;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [63:0]       tick_t;
  typedef logic [31:0]       period_t;

endpackage

// ----- hw/rtl/timer_expiry_queue_top.sv -----
// Timer expiry queue: slot table in synchronous memories with a scanning expiry engine.
//
// The block keeps NUM_SLOTS timer slots. Each slot has an armed bit (held in flip-flops
// and cleared by reset) and an expiry time and reload period held in two one-port-read
// synchronous memories. A request is taken at a rising edge where start is high and busy
// is low. Insert and remove are handled at the accepting edge: their single result shows
// on the result ports in the next cycle and busy stays low, so such requests may follow
// one another in every cycle. A process request raises busy and runs one scan of the
// expiry memory per result: each scan reads one slot per cycle, keeps the earliest
// expired slot not yet fired in this request (lowest slot on ties), and then fires it,
// re-arming a periodic slot at now plus its period or disarming a one-shot slot. Each
// scan steps through the slots in S_SCAN, then passes S_DRAIN and S_DECIDE; its pace is
// set by the single read port of the expiry memory, and a process request that fires
// k slots runs k + 1 scans with busy high. Because whether a fired result is the final
// one is only known after the following scan, each fired result is presented at the end
// of the scan that follows it. Every result is valid for exactly one cycle, marked by
// strobe; the receiver cannot stall the block, and busy is already low in the cycle
// that carries the final result of a request. The expiry and period memories need no
// clearing after reset, since an entry is only used while its slot is armed.
module timer_expiry_queue_top
  import teq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [3:0]  slot,
  input  logic [63:0] now,
  input  logic [31:0] delay,
  input  logic [31:0] period,
  output logic        strobe,
  output logic [3:0]  slot_out,
  output logic [1:0]  status,
  output logic        last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t state;

  // Slot memories: expiry time and reload period, one read address per cycle.
  tick_t   exp_mem [NUM_SLOTS];
  period_t per_mem [NUM_SLOTS];
  tick_t   exp_q;
  period_t per_q;

  // Armed bits are reset, and done bits mark slots already fired in this request.
  logic [NUM_SLOTS-1:0] armed;
  logic [NUM_SLOTS-1:0] done;

  // Scan engine registers.
  slot_idx_t scan_idx;
  slot_idx_t cmp_idx;
  logic      cmp_vld;
  tick_t     now_r;
  logic      found;
  slot_idx_t best_idx;
  tick_t     best_exp;
  period_t   best_per;

  // A fired slot waits here until the next scan tells whether it is the final result.
  logic      pend_vld;
  slot_idx_t pend_slot;

  logic      accept;
  logic      slot_ok;
  slot_idx_t slot_idx;
  period_t   after;
  logic      ins_wr;
  logic      fire_wr;
  logic      wr_en;
  slot_idx_t wr_idx;
  tick_t     wr_exp;
  period_t   wr_per;
  logic      hit;

  assign accept   = start && !busy;
  assign slot_ok  = (32'(slot) < 32'(NUM_SLOTS));
  assign slot_idx = SLOT_W'(slot);
  assign after    = (period != '0) ? period : delay;

  // Insert writes at the accepting edge; a periodic fire writes the re-armed expiry.
  assign ins_wr  = accept && (kind == KIND_INSERT) && slot_ok;
  assign fire_wr = (state == S_DECIDE) && found && (best_per != '0);
  assign wr_en   = ins_wr || fire_wr;
  assign wr_idx  = ins_wr ? slot_idx : best_idx;
  assign wr_exp  = ins_wr ? (now + 64'(after)) : (now_r + 64'(best_per));
  assign wr_per  = ins_wr ? period : best_per;

  // A slot is a candidate when it is armed, not yet fired, expired, and strictly earlier
  // than the best so far; the ascending scan order settles ties on the lowest slot.
  assign hit = cmp_vld && armed[cmp_idx] && !done[cmp_idx] && (exp_q <= now_r) &&
               (!found || (exp_q < best_exp));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      exp_mem[wr_idx] <= wr_exp;
      per_mem[wr_idx] <= wr_per;
    end
    exp_q <= exp_mem[scan_idx];
    per_q <= per_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      busy     <= 1'b0;
      strobe   <= 1'b0;
      armed    <= '0;
      done     <= '0;
      found    <= 1'b0;
      pend_vld <= 1'b0;
      cmp_vld  <= 1'b0;
      scan_idx <= '0;
    end else begin
      strobe  <= 1'b0;
      cmp_vld <= 1'b0;

      if (hit) begin
        found    <= 1'b1;
        best_idx <= cmp_idx;
        best_exp <= exp_q;
        best_per <= per_q;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_INSERT: begin
                if (slot_ok) begin
                  armed[slot_idx] <= 1'b1;
                end
                strobe   <= 1'b1;
                slot_out <= slot;
                status   <= ST_ACK;
                last     <= 1'b1;
              end
              KIND_REMOVE: begin
                if (slot_ok && armed[slot_idx]) begin
                  armed[slot_idx] <= 1'b0;
                  status          <= ST_ACK;
                end else begin
                  status <= ST_IDLE_REMOVE;
                end
                strobe   <= 1'b1;
                slot_out <= slot;
                last     <= 1'b1;
              end
              KIND_PROCESS: begin
                now_r    <= now;
                done     <= '0;
                found    <= 1'b0;
                pend_vld <= 1'b0;
                scan_idx <= '0;
                busy     <= 1'b1;
                state    <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          cmp_vld <= 1'b1;
          cmp_idx <= scan_idx;
          if (scan_idx == LAST_SLOT) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        S_DRAIN: begin
          state <= S_DECIDE;
        end

        S_DECIDE: begin
          if (pend_vld) begin
            strobe   <= 1'b1;
            slot_out <= 4'(pend_slot);
            status   <= ST_FIRED;
            last     <= !found;
          end
          if (found) begin
            done[best_idx] <= 1'b1;
            if (best_per == '0) begin
              armed[best_idx] <= 1'b0;
            end
            pend_vld  <= 1'b1;
            pend_slot <= best_idx;
            found     <= 1'b0;
            scan_idx  <= '0;
            state     <= S_SCAN;
          end else begin
            if (!pend_vld) begin
              strobe   <= 1'b1;
              slot_out <= 4'd0;
              status   <= ST_NONE;
              last     <= 1'b1;
            end
            pend_vld <= 1'b0;
            busy     <= 1'b0;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/teq_checker.sv -----
// Port-level checker for the timer expiry queue, with its bind to the top level.
module teq_checker
  import teq_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] kind,
  input logic       strobe,
  input logic [3:0] slot_out,
  input logic [1:0] status,
  input logic       last
);

  // An accepted process request always makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_PROCESS)) |=> busy)
    else $error("process request did not raise busy");

  // Only fired results may be followed by more results of the same request.
  assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == ST_ACK || status == ST_NONE || status == ST_IDLE_REMOVE)) |-> last)
    else $error("non-fired result without last");

  // The final result of a request is shown while the block already takes requests.
  assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("busy still high with final result");

  // Results within one process request never come back to back (they are a full scan apart).
  assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> !strobe)
    else $error("fired results back to back");

  // An empty process reports slot zero.
  assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == ST_NONE)) |-> (slot_out == 4'd0))
    else $error("nothing-expired result with nonzero slot");

endmodule

bind timer_expiry_queue_top teq_checker u_teq_checker (.*);

// ----- verif/timer_expiry_queue_top_test.sv -----
// Self-checking testbench for the timer expiry queue, with its own model of the slot table.
`timescale 1ns / 100ps

import teq_pkg::*;

class timer_scoreboard;
  typedef struct packed {
    logic [3:0] slot;
    logic [1:0] status;
    logic       last;
  } timer_result_t;

  bit          slot_armed[NUM_SLOTS];
  logic [63:0] slot_expiry[NUM_SLOTS];
  logic [31:0] slot_reload[NUM_SLOTS];

  timer_result_t pending_results[$];

  int errors;
  int inserts;
  int removes;
  int idle_removes;
  int scans;
  int empty_scans;
  int fired_total;
  int max_fired;

  function new();
    foreach (slot_armed[i]) slot_armed[i] = 1'b0;
  endfunction

  // Updates the slot table for one accepted request and queues the results it causes.
  function void note_request(logic [1:0] kind, logic [3:0] slot, logic [63:0] now,
                             logic [31:0] delay, logic [31:0] period);
    bit          fired[NUM_SLOTS];
    int          best;
    int          n;
    logic [31:0] after;
    case (kind)
      KIND_INSERT: begin
        inserts++;
        if (int'(slot) < NUM_SLOTS) begin
          after = (period != 32'd0) ? period : delay;
          slot_expiry[slot] = now + {32'd0, after};
          slot_reload[slot] = period;
          slot_armed[slot]  = 1'b1;
        end
        pending_results.push_back({slot, ST_ACK, 1'b1});
      end
      KIND_REMOVE: begin
        removes++;
        if (int'(slot) < NUM_SLOTS && slot_armed[slot]) begin
          slot_armed[slot] = 1'b0;
          pending_results.push_back({slot, ST_ACK, 1'b1});
        end else begin
          idle_removes++;
          pending_results.push_back({slot, ST_IDLE_REMOVE, 1'b1});
        end
      end
      KIND_PROCESS: begin
        scans++;
        foreach (fired[i]) fired[i] = 1'b0;
        n    = 0;
        best = 0;
        while (best >= 0) begin
          best = -1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_armed[i] || fired[i] || slot_expiry[i] > now) continue;
            if (best < 0 || slot_expiry[i] < slot_expiry[best]) best = i;
          end
          if (best >= 0) begin
            // A slot fires once per request even when its wrapped re-arm is already due.
            fired[best] = 1'b1;
            if (slot_reload[best] != 32'd0)
              slot_expiry[best] = now + {32'd0, slot_reload[best]};
            else
              slot_armed[best] = 1'b0;
            pending_results.push_back({4'(best), ST_FIRED, 1'b0});
            n++;
          end
        end
        if (n == 0) begin
          empty_scans++;
          pending_results.push_back({4'd0, ST_NONE, 1'b1});
        end else begin
          pending_results[pending_results.size() - 1].last = 1'b1;
        end
        fired_total += n;
        if (n > max_fired) max_fired = n;
      end
      default: ;
    endcase
  endfunction

  function void flag(string what, timer_result_t want, timer_result_t got);
    errors++;
    if (errors <= 10)
      $display("ERROR %0t %s: want slot %0d st %0d last %0d, got slot %0d st %0d last %0d",
               $realtime, what, want.slot, want.status, want.last, got.slot, got.status,
               got.last);
  endfunction

  // Compares one strobed result with the oldest expected one.
  function void check_result(logic [3:0] slot, logic [1:0] status, logic last);
    timer_result_t got;
    timer_result_t want;
    got = {slot, status, last};
    if (pending_results.size() == 0) begin
      flag("result with nothing outstanding", '0, got);
    end else begin
      want = pending_results.pop_front();
      if (got !== want) flag("result mismatch", want, got);
    end
  endfunction
endclass

module timer_expiry_queue_top_test;

  // Kind code that the block must ignore; the package names only the three real kinds.
  localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
  localparam logic [63:0] ALL_ONES     = '1;
  // Longest correct silence is the start of a process request: its first result comes
  // at the end of its second scan, later ones one scan apart, plus a long sender gap;
  // this is well beyond that.
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS       = 330;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [3:0]  slot;
  logic [63:0] now;
  logic [31:0] delay;
  logic [31:0] period;
  logic        strobe;
  logic [3:0]  slot_out;
  logic [1:0]  status;
  logic        last;

  timer_scoreboard timers;

  int          issued;
  int          quiet_cycles;
  logic [63:0] tick;

  timer_expiry_queue_top dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .kind     (kind),
    .slot     (slot),
    .now      (now),
    .delay    (delay),
    .period   (period),
    .strobe   (strobe),
    .slot_out (slot_out),
    .status   (status),
    .last     (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // All sampling happens here, at the rising edge, on values that settled at the
  // preceding falling edge. The result check runs before the new request is noted, so a
  // request accepted at this edge can never be matched against a result shown in the
  // same cycle. The same block keeps the watchdog: any cycle with neither a request
  // nor a result accepted counts toward the limit.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (strobe) timers.check_result(slot_out, status, last);
      if (start && !busy) timers.note_request(kind, slot, now, delay, period);
      if (strobe || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Timeout: nothing accepted for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, timers.pending_results.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one request from a falling edge and returns at the falling edge after it
  // was taken. Start stays high on return, so back-to-back requests keep it high; it
  // only drops while the sender idles. The idle rate follows the phase of the run:
  // light idling first, heavy idling next, none at the end.
  task automatic send_request(input logic [1:0] k, input logic [3:0] s,
                              input logic [63:0] t, input logic [31:0] d,
                              input logic [31:0] p);
    int idle_pct;
    idle_pct = (issued < ITEMS / 3) ? 10 : (issued < 2 * ITEMS / 3) ? 54 : 0;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start  = 1'b1;
    kind   = k;
    slot   = s;
    now    = t;
    delay  = d;
    period = p;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (k != KIND_UNKNOWN) issued++;
  endtask

  initial begin
    int          roll;
    int          op;
    int          phase;
    logic [31:0] p;
    logic [31:0] d;
    timers = new();
    issued = 0;
    phase  = 0;
    tick   = 64'd0;
    rst    = 1'b1;
    start  = 1'b0;
    kind   = KIND_INSERT;
    slot   = '0;
    now    = '0;
    delay  = '0;
    period = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. An empty table first: nothing expired, and a remove of an idle slot.
    send_request(KIND_PROCESS, 4'd0, 64'd0, 32'd0, 32'd0);
    send_request(KIND_REMOVE, 4'd0, 64'd0, 32'd0, 32'd0);
    // A one-shot, a periodic slot whose delay must be ignored, and an overwritten slot.
    send_request(KIND_INSERT, 4'd0, 64'd0, 32'd5, 32'd0);
    send_request(KIND_INSERT, LAST_SLOT, 64'd0, 32'hFFFF_FFFF, 32'd5);
    send_request(KIND_INSERT, 4'd7, 64'd0, 32'd3, 32'd0);
    send_request(KIND_INSERT, 4'd7, 64'd0, 32'd10, 32'd0);
    // One tick early nothing fires; then a tie on expiry time resolved by slot order;
    // then the re-armed periodic slot ties again with the overwritten one.
    send_request(KIND_PROCESS, 4'd0, 64'd4, 32'd0, 32'd0);
    send_request(KIND_PROCESS, 4'd0, 64'd5, 32'd0, 32'd0);
    send_request(KIND_PROCESS, 4'd0, 64'd10, 32'd0, 32'd0);
    // Remove an armed slot, then the same slot again once it is idle.
    send_request(KIND_REMOVE, LAST_SLOT, 64'd0, 32'd0, 32'd0);
    send_request(KIND_REMOVE, LAST_SLOT, 64'd0, 32'd0, 32'd0);
    // Field extremes near the top of time: both expiries wrap past zero. The periodic
    // slot re-arms to a wrapped time that is already due, yet fires once per request.
    send_request(KIND_INSERT, LAST_SLOT, ALL_ONES, 32'hFFFF_FFFF, 32'd0);
    send_request(KIND_INSERT, 4'd3, ALL_ONES - 64'd15, 32'd0, 32'hFFFF_FFFF);
    send_request(KIND_PROCESS, 4'd0, ALL_ONES, 32'd0, 32'd0);
    send_request(KIND_PROCESS, 4'd0, ALL_ONES, 32'd0, 32'd0);
    send_request(KIND_REMOVE, 4'd3, ALL_ONES, 32'd0, 32'd0);
    // An unknown kind with every bit set must leave no trace.
    send_request(KIND_UNKNOWN, LAST_SLOT, ALL_ONES, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random part. Most requests follow a slowly advancing time so that timers really
    // come due; each later phase starts its time base elsewhere, the last one just
    // below the wrap point so that time runs through zero.
    while (issued < ITEMS) begin
      if (phase == 0 && issued >= ITEMS / 3) begin
        phase = 1;
        tick  = {$urandom, $urandom};
      end else if (phase == 1 && issued >= 2 * ITEMS / 3) begin
        phase = 2;
        tick  = ALL_ONES - 64'd400;
      end
      roll = $urandom_range(99);
      if (roll < 60) begin
        tick += 64'($urandom_range(0, 6));
        op = $urandom_range(99);
        if (op < 45) begin
          if ($urandom_range(1) == 0)
            p = 32'd0;
          else if ($urandom_range(19) == 0)
            p = $urandom;
          else
            p = $urandom_range(1, 40);
          // With a period the delay is don't-care, so it carries random bits.
          d = (p != 32'd0 || $urandom_range(9) == 0) ? $urandom : $urandom_range(0, 40);
          send_request(KIND_INSERT, 4'($urandom_range(NUM_SLOTS - 1)), tick, d, p);
        end else if (op < 60) begin
          send_request(KIND_REMOVE, 4'($urandom_range(NUM_SLOTS - 1)), tick, $urandom,
                       $urandom);
        end else begin
          send_request(KIND_PROCESS, 4'($urandom_range(NUM_SLOTS - 1)), tick, $urandom,
                       $urandom);
        end
      end else if (roll < 70) begin
        // Arm every slot close together, then process once all are due: the request
        // with the most results, ordered mostly by expiry time.
        for (int i = 0; i < NUM_SLOTS; i++)
          send_request(KIND_INSERT, 4'(i), tick, $urandom_range(0, 3), $urandom_range(0, 3));
        tick += 64'd4;
        send_request(KIND_PROCESS, 4'd0, tick, $urandom, $urandom);
      end else if (roll < 95) begin
        send_request(2'($urandom_range(2)), 4'($urandom_range(NUM_SLOTS - 1)),
                     {$urandom, $urandom}, $urandom, $urandom);
      end else begin
        send_request(KIND_UNKNOWN, 4'($urandom_range(NUM_SLOTS - 1)), {$urandom, $urandom},
                     $urandom, $urandom);
      end
    end
    start = 1'b0;

    // Drain, then watch a couple of scan lengths for stray results.
    while (timers.pending_results.size() != 0) @(posedge clk);
    repeat (2 * (NUM_SLOTS + 2)) @(posedge clk);

    $display("Run covered %0d inserts, %0d removes (%0d of idle slots), %0d process requests",
             timers.inserts, timers.removes, timers.idle_removes, timers.scans);
    $display("Timers fired: %0d in total, up to %0d in one request; %0d found nothing due",
             timers.fired_total, timers.max_fired, timers.empty_scans);
    if (timers.errors == 0 && timers.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d results outstanding", timers.errors,
               timers.pending_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
